### rtl/core/xcrc_pkg.sv
package xcrc_pkg;

    // frame geometry: block number, inverse, payload, two crc bytes
    localparam int unsigned BLOCK_BYTES = 128;
    localparam int unsigned POS_W       = 8;
    localparam int unsigned IDX_W       = 7;

    localparam logic [POS_W-1:0] POS_BLOCK    = POS_W'(0);
    localparam logic [POS_W-1:0] POS_INVERSE  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_DATA     = POS_W'(2);
    localparam logic [POS_W-1:0] POS_CRC_HIGH = POS_W'(2 + BLOCK_BYTES);

    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] SYNC_RETRY_RESET = 8'd60;

    // commands
    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_BYTE    = 2'd1;
    localparam logic [1:0] CMD_TIMEOUT = 2'd2;

    // protocol bytes
    localparam logic [7:0] BYTE_SOH = 8'h01;
    localparam logic [7:0] BYTE_EOT = 8'h04;
    localparam logic [7:0] BYTE_ACK = 8'h06;
    localparam logic [7:0] BYTE_NAK = 8'h15;
    localparam logic [7:0] BYTE_CAN = 8'h18;
    localparam logic [7:0] BYTE_C   = 8'h43;

    // events
    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_GOOD      = 3'd1;
    localparam logic [2:0] EV_DUP       = 3'd2;
    localparam logic [2:0] EV_REJ       = 3'd3;
    localparam logic [2:0] EV_END       = 3'd4;
    localparam logic [2:0] EV_ABORT     = 3'd5;
    localparam logic [2:0] EV_SYNCFAIL  = 3'd6;

    // apb register map
    localparam logic [2:0] ADDR_SYNC_RETRY_LIMIT = 3'd0;

endpackage

### rtl/core/xcrc_crc16_step.sv
module xcrc_crc16_step (
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [15:0] crc_out
);
    import xcrc_pkg::*;

    logic [15:0] crc_v;

    // msb-first, one bit per step
    always_comb begin
        crc_v = crc_in ^ {data_in, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (crc_v[15]) begin
                crc_v = {crc_v[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc_v = {crc_v[14:0], 1'b0};
            end
        end
        crc_out = crc_v;
    end

endmodule

### rtl/core/xmodem_crc_receiver_core.sv
// xmodem-crc receiver, 128-byte blocks. one request in (start, received byte or
// timeout) gives exactly one result out, carrying an optional byte to send back
// ('C', ACK or NAK), an optional payload byte with its index, an event code and
// the block number. payload bytes leave as soon as they arrive; the verdict
// comes with the second crc byte, so a consumer holds the block until event
// good or duplicate. the crc update is an eight step xor network that feeds the
// crc state register, and a new request is taken every cycle while the output
// register is empty or being drained. sync_retry_limit sits at apb address 0
// and should only be written while no request is in flight.
module xmodem_crc_receiver_core (
    input  logic        aclk,
    input  logic        aresetn,
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [7:0]  s_rx_byte,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_tx_valid,
    output logic [7:0]  m_tx_byte,
    output logic        m_data_valid,
    output logic [7:0]  m_data_byte,
    output logic [6:0]  m_data_index,
    output logic [2:0]  m_event_res,
    output logic [7:0]  m_block_number
);
    import xcrc_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SYNC,
        PH_CTRL,
        PH_FRAME,
        PH_DONE
    } phase_t;

    // configuration
    logic [7:0] sync_limit_reg;

    // protocol state
    phase_t        phase_reg, phase_next;
    logic [7:0]    attempts_reg, attempts_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]    expected_reg, expected_next;
    logic [7:0]    rblock_reg, rblock_next;
    logic [7:0]    rinv_reg, rinv_next;
    logic [15:0]   crc_reg, crc_next;
    logic [7:0]    crc_high_reg, crc_high_next;

    // output register
    logic          m_valid_reg;
    logic          tx_valid_reg, tx_valid_next;
    logic [7:0]    tx_byte_reg, tx_byte_next;
    logic          data_valid_reg, data_valid_next;
    logic [7:0]    data_byte_reg, data_byte_next;
    logic [IDX_W-1:0] data_index_reg, data_index_next;
    logic [2:0]    event_reg, event_next;
    logic [7:0]    block_reg, block_next;

    logic          accept;
    logic          cfg_write;
    logic [15:0]   crc_step;
    logic [7:0]    attempts_inc;
    logic          is_ctrl_byte;
    logic          inv_ok;
    logic          seq_ok;
    logic          crc_ok;

    // apb: zero wait states, single register
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & (paddr == ADDR_SYNC_RETRY_LIMIT);
    assign prdata    = (paddr == ADDR_SYNC_RETRY_LIMIT) ? {24'd0, sync_limit_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_limit_reg <= SYNC_RETRY_RESET;
        end else if (cfg_write) begin
            sync_limit_reg <= pwdata[7:0];
        end
    end

    // take a new request whenever the output register is free or draining
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    xcrc_crc16_step u_crc (
        .crc_in  (crc_reg),
        .data_in (s_rx_byte),
        .crc_out (crc_step)
    );

    assign attempts_inc = attempts_reg + 8'd1;
    assign is_ctrl_byte = (s_rx_byte == BYTE_SOH) || (s_rx_byte == BYTE_EOT)
                       || (s_rx_byte == BYTE_CAN);
    // verdict terms for the last crc byte
    assign inv_ok = ((rblock_reg + rinv_reg) == 8'hFF);
    assign seq_ok = (rblock_reg == expected_reg);
    assign crc_ok = ({crc_high_reg, s_rx_byte} == crc_reg);

    always_comb begin
        phase_next      = phase_reg;
        attempts_next   = attempts_reg;
        pos_next        = pos_reg;
        expected_next   = expected_reg;
        rblock_next     = rblock_reg;
        rinv_next       = rinv_reg;
        crc_next        = crc_reg;
        crc_high_next   = crc_high_reg;
        tx_valid_next   = 1'b0;
        tx_byte_next    = 8'd0;
        data_valid_next = 1'b0;
        data_byte_next  = 8'd0;
        data_index_next = '0;
        event_next      = EV_NONE;
        block_next      = 8'd0;

        if (s_cmd == CMD_START) begin
            // restart the session from any phase
            phase_next    = PH_SYNC;
            attempts_next = 8'd0;
            pos_next      = '0;
            expected_next = 8'd1;
            rblock_next   = 8'd0;
            rinv_next     = 8'd0;
            crc_next      = 16'd0;
            crc_high_next = 8'd0;
            if (sync_limit_reg == 8'd0) begin
                event_next = EV_SYNCFAIL;
                phase_next = PH_DONE;
            end else begin
                tx_valid_next = 1'b1;
                tx_byte_next  = BYTE_C;
            end
        end else if (s_cmd == CMD_BYTE || s_cmd == CMD_TIMEOUT) begin
            case (phase_reg)
                PH_SYNC, PH_CTRL: begin
                    if (s_cmd == CMD_BYTE && is_ctrl_byte) begin
                        case (s_rx_byte)
                            BYTE_EOT: begin
                                tx_valid_next = 1'b1;
                                tx_byte_next  = BYTE_ACK;
                                event_next    = EV_END;
                                phase_next    = PH_DONE;
                            end
                            BYTE_CAN: begin
                                event_next = EV_ABORT;
                                phase_next = PH_DONE;
                            end
                            default: begin
                                // start of header
                                phase_next    = PH_FRAME;
                                pos_next      = '0;
                                rblock_next   = 8'd0;
                                rinv_next     = 8'd0;
                                crc_next      = 16'd0;
                                crc_high_next = 8'd0;
                            end
                        endcase
                    end else if (phase_reg == PH_SYNC) begin
                        // timeout or stray byte: one more failed attempt
                        attempts_next = attempts_inc;
                        if (attempts_inc < sync_limit_reg) begin
                            tx_valid_next = 1'b1;
                            tx_byte_next  = BYTE_C;
                        end else begin
                            event_next = EV_SYNCFAIL;
                            phase_next = PH_DONE;
                        end
                    end else begin
                        tx_valid_next = 1'b1;
                        tx_byte_next  = BYTE_NAK;
                    end
                end
                PH_FRAME: begin
                    if (s_cmd == CMD_TIMEOUT) begin
                        tx_valid_next = 1'b1;
                        tx_byte_next  = BYTE_NAK;
                        event_next    = EV_REJ;
                        block_next    = (pos_reg != '0) ? rblock_reg : 8'd0;
                        phase_next    = PH_CTRL;
                        pos_next      = '0;
                    end else if (pos_reg == POS_BLOCK) begin
                        rblock_next = s_rx_byte;
                        pos_next    = pos_reg + POS_W'(1);
                    end else if (pos_reg == POS_INVERSE) begin
                        rinv_next = s_rx_byte;
                        pos_next  = pos_reg + POS_W'(1);
                    end else if (pos_reg < POS_CRC_HIGH) begin
                        // payload byte goes straight out
                        crc_next        = crc_step;
                        data_valid_next = 1'b1;
                        data_byte_next  = s_rx_byte;
                        data_index_next = IDX_W'(pos_reg - POS_DATA);
                        pos_next        = pos_reg + POS_W'(1);
                    end else if (pos_reg == POS_CRC_HIGH) begin
                        crc_high_next = s_rx_byte;
                        pos_next      = pos_reg + POS_W'(1);
                    end else begin
                        // crc low byte: block verdict
                        block_next    = rblock_reg;
                        tx_valid_next = 1'b1;
                        if (inv_ok && seq_ok && crc_ok) begin
                            expected_next = expected_reg + 8'd1;
                            tx_byte_next  = BYTE_ACK;
                            event_next    = EV_GOOD;
                        end else if (inv_ok && (rblock_reg == expected_reg - 8'd1)) begin
                            tx_byte_next = BYTE_ACK;
                            event_next   = EV_DUP;
                        end else begin
                            tx_byte_next = BYTE_NAK;
                            event_next   = EV_REJ;
                        end
                        phase_next = PH_CTRL;
                        pos_next   = '0;
                    end
                end
                default: begin
                    // idle and finished ignore bytes and timeouts
                end
            endcase
        end
    end

    // protocol state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            attempts_reg   <= 8'd0;
            pos_reg        <= '0;
            expected_reg   <= 8'd1;
            rblock_reg     <= 8'd0;
            rinv_reg       <= 8'd0;
            crc_reg        <= 16'd0;
            crc_high_reg   <= 8'd0;
            m_valid_reg    <= 1'b0;
            tx_valid_reg   <= 1'b0;
            tx_byte_reg    <= 8'd0;
            data_valid_reg <= 1'b0;
            data_byte_reg  <= 8'd0;
            data_index_reg <= '0;
            event_reg      <= EV_NONE;
            block_reg      <= 8'd0;
        end else if (accept) begin
            phase_reg      <= phase_next;
            attempts_reg   <= attempts_next;
            pos_reg        <= pos_next;
            expected_reg   <= expected_next;
            rblock_reg     <= rblock_next;
            rinv_reg       <= rinv_next;
            crc_reg        <= crc_next;
            crc_high_reg   <= crc_high_next;
            m_valid_reg    <= 1'b1;
            tx_valid_reg   <= tx_valid_next;
            tx_byte_reg    <= tx_byte_next;
            data_valid_reg <= data_valid_next;
            data_byte_reg  <= data_byte_next;
            data_index_reg <= data_index_next;
            event_reg      <= event_next;
            block_reg      <= block_next;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_tx_valid     = tx_valid_reg;
    assign m_tx_byte      = tx_byte_reg;
    assign m_data_valid   = data_valid_reg;
    assign m_data_byte    = data_byte_reg;
    assign m_data_index   = data_index_reg;
    assign m_event_res    = event_reg;
    assign m_block_number = block_reg;

endmodule

### tb/xmodem_crc_receiver_core_tb.sv
`timescale 1ns / 100ps

module xmodem_crc_receiver_core_tb;

    import xcrc_pkg::*;

    // command code the block has no use for: dropped with an empty reply
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int unsigned IDLE_PERCENT    = 36;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned WATCHDOG_LIMIT  = 4000;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned PHASE_ITEMS     = 320;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SYNC,
        PH_CTRL,
        PH_FRAME,
        PH_DONE
    } session_phase_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       data_valid;
        logic [7:0] data_byte;
        logic [6:0] data_index;
        logic [2:0] event_res;
        logic [7:0] block_number;
    } reply_t;

    // tracks the receiver session and keeps the replies still owed by the block
    class reply_tracker;
        logic [7:0]     retry_limit;
        session_phase_t session_phase;
        logic [7:0]     sync_tries;
        logic [7:0]     frame_pos;
        logic [7:0]     next_block;
        logic [7:0]     got_block;
        logic [7:0]     got_inverse;
        logic [7:0]     crc_high;
        logic [15:0]    crc_acc;
        reply_t         pending_replies[$];
        int unsigned    errors;

        function new();
            retry_limit   = SYNC_RETRY_RESET;
            session_phase = PH_IDLE;
            errors        = 0;
            clear_session();
        endfunction

        static function logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
            logic [15:0] acc;
            acc = crc ^ {b, 8'h00};
            for (int k = 0; k < 8; k++) begin
                acc = acc[15] ? ((acc << 1) ^ CRC_POLY) : (acc << 1);
            end
            return acc;
        endfunction

        function void clear_session();
            sync_tries  = '0;
            frame_pos   = '0;
            next_block  = 8'd1;
            got_block   = '0;
            got_inverse = '0;
            crc_acc     = '0;
            crc_high    = '0;
        endfunction

        function void answer(inout reply_t r, input logic [7:0] b);
            r.tx_valid = 1'b1;
            r.tx_byte  = b;
        endfunction

        // SOH, EOT and CAN steer the session; anything else is not a control byte
        function bit accept_control(input logic [7:0] b, inout reply_t r);
            case (b)
                BYTE_EOT: begin
                    answer(r, BYTE_ACK);
                    r.event_res   = EV_END;
                    session_phase = PH_DONE;
                end
                BYTE_CAN: begin
                    r.event_res   = EV_ABORT;
                    session_phase = PH_DONE;
                end
                BYTE_SOH: begin
                    session_phase = PH_FRAME;
                    frame_pos     = '0;
                    got_block     = '0;
                    got_inverse   = '0;
                    crc_acc       = '0;
                    crc_high      = '0;
                end
                default: return 1'b0;
            endcase
            return 1'b1;
        endfunction

        function void count_sync_miss(inout reply_t r);
            sync_tries++;
            if (sync_tries < retry_limit) begin
                answer(r, BYTE_C);
            end else begin
                r.event_res   = EV_SYNCFAIL;
                session_phase = PH_DONE;
            end
        endfunction

        function void take_frame_byte(input logic [7:0] b, inout reply_t r);
            bit inv_ok;
            if (frame_pos == POS_BLOCK) begin
                got_block = b;
            end else if (frame_pos == POS_INVERSE) begin
                got_inverse = b;
            end else if (frame_pos < POS_CRC_HIGH) begin
                crc_acc      = crc16_update(crc_acc, b);
                r.data_valid = 1'b1;
                r.data_byte  = b;
                r.data_index = 7'(frame_pos - POS_DATA);
            end else if (frame_pos == POS_CRC_HIGH) begin
                crc_high = b;
            end else begin
                // last crc byte: verdict on the whole block
                inv_ok         = 8'(got_block + got_inverse) == 8'hFF;
                r.block_number = got_block;
                if (inv_ok && got_block == next_block && {crc_high, b} == crc_acc) begin
                    next_block++;
                    answer(r, BYTE_ACK);
                    r.event_res = EV_GOOD;
                end else if (inv_ok && got_block == 8'(next_block - 8'd1)) begin
                    answer(r, BYTE_ACK);
                    r.event_res = EV_DUP;
                end else begin
                    answer(r, BYTE_NAK);
                    r.event_res = EV_REJ;
                end
                session_phase = PH_CTRL;
                frame_pos     = '0;
                return;
            end
            frame_pos++;
        endfunction

        function reply_t predict_reply(input logic [1:0] cmd, input logic [7:0] b);
            reply_t r;
            r = '0;
            if (cmd == CMD_START) begin
                session_phase = PH_SYNC;
                clear_session();
                if (retry_limit == 8'd0) begin
                    r.event_res   = EV_SYNCFAIL;
                    session_phase = PH_DONE;
                end else begin
                    answer(r, BYTE_C);
                end
            end else if (cmd != CMD_UNUSED) begin
                case (session_phase)
                    PH_SYNC: begin
                        if (cmd == CMD_TIMEOUT || !accept_control(b, r)) count_sync_miss(r);
                    end
                    PH_CTRL: begin
                        if (cmd == CMD_TIMEOUT || !accept_control(b, r)) answer(r, BYTE_NAK);
                    end
                    PH_FRAME: begin
                        if (cmd == CMD_TIMEOUT) begin
                            answer(r, BYTE_NAK);
                            r.event_res    = EV_REJ;
                            r.block_number = (frame_pos != 0) ? got_block : 8'd0;
                            session_phase  = PH_CTRL;
                            frame_pos      = '0;
                        end else begin
                            take_frame_byte(b, r);
                        end
                    end
                    default: ;
                endcase
            end
            return r;
        endfunction

        function void note_request(input logic [1:0] cmd, input logic [7:0] b);
            pending_replies.push_back(predict_reply(cmd, b));
        endfunction

        function void compare_field(input string name, input int unsigned want,
                                    input int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
            end
        endfunction

        function void check_reply(input reply_t got);
            reply_t want;
            if (pending_replies.size() == 0) begin
                errors++;
                $display("%0t: reply with nothing pending, expected none, actual 0x%0h",
                         $time, got);
                return;
            end
            want = pending_replies.pop_front();
            compare_field("tx_valid", want.tx_valid, got.tx_valid);
            compare_field("tx_byte", want.tx_byte, got.tx_byte);
            compare_field("data_valid", want.data_valid, got.data_valid);
            compare_field("data_byte", want.data_byte, got.data_byte);
            compare_field("data_index", want.data_index, got.data_index);
            compare_field("event_res", want.event_res, got.event_res);
            compare_field("block_number", want.block_number, got.block_number);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd = CMD_START;
    logic [7:0]  s_rx_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_tx_valid;
    logic [7:0]  m_tx_byte;
    logic        m_data_valid;
    logic [7:0]  m_data_byte;
    logic [6:0]  m_data_index;
    logic [2:0]  m_event_res;
    logic [7:0]  m_block_number;

    reply_tracker tracker;
    bit           calm_stretch = 1'b0;  // no idling on either side while set
    bit           hold_off_req = 1'b0;  // asks the result side for one long stall
    int unsigned  sent_items = 0;
    int unsigned  stall_cycles = 0;

    xmodem_crc_receiver_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_tx_valid     (m_tx_valid),
        .m_tx_byte      (m_tx_byte),
        .m_data_valid   (m_data_valid),
        .m_data_byte    (m_data_byte),
        .m_data_index   (m_data_index),
        .m_event_res    (m_event_res),
        .m_block_number (m_block_number)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // synchronous reset, held at start-up only and never again
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // result side: random back-pressure, one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= calm_stretch || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // every reply taken off the result channel is checked in order
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.check_reply(reply_t'({m_tx_valid, m_tx_byte, m_data_valid, m_data_byte,
                                          m_data_index, m_event_res, m_block_number}));
        end
    end

    // watchdog: too long without any handshake on either channel ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // one request: optional random gap, then hold valid until the block takes it
    task automatic push_request(input logic [1:0] cmd, input logic [7:0] rx);
        while (!calm_stretch && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_cmd     <= cmd;
        s_rx_byte <= rx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.note_request(cmd, rx);
        sent_items++;
    endtask

    // stop offering and let every owed reply come out
    task automatic drain_replies();
        s_valid <= 1'b0;
        while (tracker.pending_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic set_retry_limit(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_SYNC_RETRY_LIMIT;
        pwdata  <= {24'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.retry_limit = value;
    endtask

    function automatic logic [7:0] stray_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom);
        end while (b == BYTE_SOH || b == BYTE_EOT || b == BYTE_CAN);
        return b;
    endfunction

    // line noise: timeout, a non-control byte or an unused command
    task automatic send_noise();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 5) begin
            push_request(CMD_TIMEOUT, 8'($urandom));
        end else if (pick < 9) begin
            push_request(CMD_BYTE, stray_byte());
        end else begin
            push_request(CMD_UNUSED, 8'($urandom));
        end
    endtask

    // one SOH frame; mostly good, else duplicate, out of sequence, bad inverse,
    // bad crc, or cut short by a timeout or a fresh start
    task automatic send_block();
        int unsigned pick;
        int unsigned cut_at;
        int unsigned pos;
        logic [7:0]  blk;
        logic [7:0]  inv;
        logic [7:0]  payload;
        logic [15:0] crc;
        logic [1:0]  cut_cmd;
        bit          bad_crc;
        pick    = $urandom_range(99);
        blk     = tracker.next_block;
        inv     = ~blk;
        bad_crc = 1'b0;
        cut_at  = BLOCK_BYTES + 4;
        cut_cmd = CMD_TIMEOUT;
        crc     = '0;
        if (pick >= 93) begin
            cut_at = $urandom_range(0, BLOCK_BYTES + 3);
            if ($urandom_range(3) == 0) cut_cmd = CMD_START;
        end else if (pick >= 87) begin
            bad_crc = 1'b1;
        end else if (pick >= 82) begin
            inv = inv ^ 8'($urandom_range(1, 255));
        end else if (pick >= 76) begin
            blk = blk + 8'($urandom_range(2, 254));
            inv = ~blk;
        end else if (pick >= 68) begin
            blk = blk - 8'd1;
            inv = ~blk;
        end
        push_request(CMD_BYTE, BYTE_SOH);
        for (pos = 0; pos < BLOCK_BYTES + 4; pos++) begin
            if (pos == cut_at) begin
                push_request(cut_cmd, 8'($urandom));
                return;
            end
            // an unused command inside a frame must leave it untouched
            if ($urandom_range(199) == 0) push_request(CMD_UNUSED, 8'($urandom));
            if (pos == 0) begin
                payload = blk;
            end else if (pos == 1) begin
                payload = inv;
            end else if (pos < BLOCK_BYTES + 2) begin
                payload = 8'($urandom);
                crc     = reply_tracker::crc16_update(crc, payload);
            end else begin
                if (pos == BLOCK_BYTES + 2 && bad_crc) crc ^= 16'd1 << $urandom_range(15);
                payload = (pos == BLOCK_BYTES + 2) ? crc[15:8] : crc[7:0];
            end
            push_request(CMD_BYTE, payload);
        end
    endtask

    // start, a few failed sync attempts (now and then enough to give up),
    // some blocks with noise between them, then EOT, CAN or nothing
    task automatic run_session();
        int unsigned misses;
        int unsigned blocks;
        int unsigned k;
        int unsigned pick;
        push_request(CMD_START, 8'($urandom));
        misses = ($urandom_range(9) == 0) ? tracker.retry_limit : $urandom_range(0, 3);
        for (k = 0; k < misses && tracker.session_phase == PH_SYNC; k++) send_noise();
        blocks = $urandom_range(1, 4);
        for (k = 0; k < blocks; k++) begin
            if (!(tracker.session_phase inside {PH_SYNC, PH_CTRL})) break;
            if (tracker.session_phase == PH_CTRL && $urandom_range(3) == 0) send_noise();
            send_block();
        end
        if (tracker.session_phase == PH_CTRL) begin
            pick = $urandom_range(9);
            if (pick < 6) begin
                push_request(CMD_BYTE, BYTE_EOT);
            end else if (pick < 9) begin
                push_request(CMD_BYTE, BYTE_CAN);
            end
        end
        // now and then noise afterwards; once the session has ended, all but a start is dropped
        if ($urandom_range(7) == 0) send_noise();
    endtask

    initial begin
        logic [7:0]  limits [5];
        int unsigned step;
        int unsigned quota_base;
        tracker = new();
        limits  = '{8'd1, 8'd255, 8'd2, SYNC_RETRY_RESET, 8'($urandom_range(3, 254))};
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);

        // idle: everything but start is dropped
        push_request(CMD_UNUSED, 8'hFF);
        push_request(CMD_BYTE, 8'hFF);
        push_request(CMD_TIMEOUT, 8'h00);
        // sync: timeouts and stray bytes ask again with 'C'
        push_request(CMD_START, 8'h00);
        push_request(CMD_TIMEOUT, 8'hFF);
        push_request(CMD_BYTE, 8'hAA);
        push_request(CMD_UNUSED, 8'h55);
        push_request(CMD_BYTE, 8'h00);
        // frame cut by a timeout before the block number
        push_request(CMD_BYTE, BYTE_SOH);
        push_request(CMD_TIMEOUT, 8'h00);
        // awaiting a control byte: junk and timeout both draw NAK
        push_request(CMD_BYTE, 8'hFF);
        push_request(CMD_TIMEOUT, 8'h00);
        // frame cut after the block number, then end of transfer
        push_request(CMD_BYTE, BYTE_SOH);
        push_request(CMD_BYTE, 8'hFF);
        push_request(CMD_TIMEOUT, 8'h00);
        push_request(CMD_BYTE, BYTE_EOT);
        push_request(CMD_BYTE, BYTE_SOH);
        // abort, then restarts: one from sync, one in the middle of a frame
        push_request(CMD_START, 8'hFF);
        push_request(CMD_BYTE, BYTE_CAN);
        push_request(CMD_START, 8'h00);
        push_request(CMD_BYTE, BYTE_SOH);
        push_request(CMD_BYTE, 8'h01);
        push_request(CMD_START, 8'h00);
        push_request(CMD_START, 8'h00);
        push_request(CMD_BYTE, BYTE_EOT);

        // zero retry limit: start gives up at once
        drain_replies();
        set_retry_limit(8'd0);
        push_request(CMD_START, 8'h00);
        push_request(CMD_TIMEOUT, 8'h00);

        // random sessions under several limits, extremes included;
        // one long stall on the result side, one stretch with no idling
        quota_base = sent_items;
        for (step = 0; step < 5; step++) begin
            drain_replies();
            set_retry_limit(limits[step]);
            calm_stretch = (step == 3);
            if (step == 1) hold_off_req = 1'b1;
            do begin
                run_session();
            end while (sent_items - quota_base < (step + 1) * PHASE_ITEMS);
        end

        drain_replies();
        if (tracker.errors == 0 && tracker.pending_replies.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

### xmodem_crc_receiver_core.f
rtl/core/xcrc_pkg.sv
rtl/core/xcrc_crc16_step.sv
rtl/core/xmodem_crc_receiver_core.sv
tb/xmodem_crc_receiver_core_tb.sv
